/* src/bavg_pkg.sv */
// Shared types and constants for the block average downsampler.
// Holds register codes, reset values, FSM and divider op enums, and the
// command/status structs between controller and datapath. No dependencies.
package bavg_pkg;

    // Default sizing of the block
    localparam int DEF_MAX_COLS       = 1024;
    localparam int DEF_MAX_BLOCK_SIDE = 16;
    localparam int DEF_PIXEL_BITS     = 8;

    // Configuration port layout
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SIDE_REG_W = 5;
    localparam int DIM_REG_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd2;

    localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 5'd2;
    localparam logic [DIM_REG_W-1:0]  COLS_RESET = 11'd640;
    localparam logic [DIM_REG_W-1:0]  ROWS_RESET = 11'd480;

    // Controller states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_ACC,
        ST_DIV_START,
        ST_DIV_WAIT
    } bavg_state_t;

    // What the shared divider is working on
    typedef enum logic [2:0] {
        OP_COLS,
        OP_ROWS,
        OP_PCOL,
        OP_PROW,
        OP_BLOCK
    } bavg_op_t;

    // Controller to datapath
    typedef struct packed {
        logic     accept;
        logic     acc_write;
        logic     div_start;
        logic     div_load;
        bavg_op_t op;
    } bavg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic seg_done;
        logic block_done;
        logic div_done;
        logic cfg_write;
        logic out_free;
    } bavg_stat_t;

endpackage

/* src/block_average_downsampler.sv */
// Top level of the block average downsampler.
// Joins the controller and the datapath. Depends on bavg_pkg, bavg_ctrl
// and bavg_datapath.
//
// Usage:
//   s_ channel: one grayscale pixel per word in raster order; frame_start
//   marks the first pixel of a frame. m_ channel: one word per complete
//   block with its truncated mean, block row/column and a row end flag.
//   cfg_ channel: block_side (0), image_cols (1), image_rows (2); always
//   ready, write only while no pixel is in flight.
// The shared bit-serial divider is DIV_W = max(PIXEL_BITS + 2*clog2(MAX_BLOCK_SIDE),
//   clog2(MAX_COLS + 1)) bits wide, 16 by default. A pixel that closes a horizontal
//   segment is followed by a line store read-modify-write; one that closes a block
//   then also runs the block division, whose result goes to the output register.
// Reset and config writes trigger a geometry recompute on the same divider: four
//   divisions (columns, rows, pixel column, pixel row) with s_ready low.
// A stalled receiver holds the result in the output register; pixel intake
// continues until the next block mean needs that register.
module block_average_downsampler #(
    parameter int MAX_COLS       = bavg_pkg::DEF_MAX_COLS,
    parameter int MAX_BLOCK_SIDE = bavg_pkg::DEF_MAX_BLOCK_SIDE,
    parameter int PIXEL_BITS     = bavg_pkg::DEF_PIXEL_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [PIXEL_BITS-1:0]           s_pixel,
    input  logic                            s_frame_start,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [PIXEL_BITS-1:0]           m_avg_value,
    output logic [$clog2(MAX_COLS)-1:0]     m_block_row,
    output logic [$clog2(MAX_COLS)-1:0]     m_block_col,
    output logic                            m_row_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0] cfg_data
);

    import bavg_pkg::*;

    bavg_cmd_t  cmd;
    bavg_stat_t stat;

    bavg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bavg_datapath #(
        .MAX_COLS       (MAX_COLS),
        .MAX_BLOCK_SIDE (MAX_BLOCK_SIDE),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_value   (m_avg_value),
        .m_block_row   (m_block_row),
        .m_block_col   (m_block_col),
        .m_row_end     (m_row_end)
    );

endmodule

/* src/bavg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the per-block-column line store. No dependencies.
module bavg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* src/bavg_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Shared by the geometry recompute and the block mean. No dependencies.
module bavg_div #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dsr_reg, dsr_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;

    // Shift in one dividend bit and try to subtract
    always_comb begin
        shifted   = {rem_reg, quo_reg[WIDTH-1]};
        trial     = shifted - {1'b0, dsr_reg};
        cnt_next  = cnt_reg;
        done_next = done_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            cnt_next  = CNT_W'(WIDTH);
            done_next = 1'b0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                done_next = 1'b1;
            end
            if (!trial[WIDTH]) begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* src/bavg_datapath.sv */
// Datapath of the block average downsampler: config registers, position
// counters, segment sum, line store, shared divider and output register.
// Depends on bavg_pkg, bavg_ram and bavg_div.
module bavg_datapath #(
    parameter int MAX_COLS       = bavg_pkg::DEF_MAX_COLS,
    parameter int MAX_BLOCK_SIDE = bavg_pkg::DEF_MAX_BLOCK_SIDE,
    parameter int PIXEL_BITS     = bavg_pkg::DEF_PIXEL_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bavg_pkg::bavg_cmd_t                 cmd,
    output bavg_pkg::bavg_stat_t                stat,
    input  logic [PIXEL_BITS-1:0]               s_pixel,
    input  logic                                s_frame_start,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [PIXEL_BITS-1:0]               m_avg_value,
    output logic [$clog2(MAX_COLS)-1:0]         m_block_row,
    output logic [$clog2(MAX_COLS)-1:0]         m_block_col,
    output logic                                m_row_end
);

    import bavg_pkg::*;

    localparam int POS_W  = $clog2(MAX_COLS);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int SIDE_W = $clog2(MAX_BLOCK_SIDE + 1);
    localparam int SUB_W  = $clog2(MAX_BLOCK_SIDE);
    localparam int SQ_W   = 2 * SIDE_W;
    localparam int SEG_W  = PIXEL_BITS + SUB_W;
    localparam int SUM_W  = PIXEL_BITS + 2 * SUB_W;
    localparam int DIV_W  = (SUM_W > CNT_W) ? SUM_W : CNT_W;

    // Configuration registers
    logic [SIDE_REG_W-1:0] side_cfg_reg;
    logic [DIM_REG_W-1:0]  cols_cfg_reg;
    logic [DIM_REG_W-1:0]  rows_cfg_reg;
    logic                  cfg_wr;

    // Clamped geometry
    logic [SIDE_W-1:0] side_c, side_m1;
    logic [SQ_W-1:0]   side_sq;
    logic [CNT_W-1:0]  cols_c, rows_c;
    logic [CNT_W-1:0]  cols_q_reg, cols_q_next;
    logic [CNT_W-1:0]  rows_q_reg, rows_q_next;

    // Position state
    logic [POS_W-1:0] pc_reg, pc_next, pr_reg, pr_next;
    logic [POS_W-1:0] bc_reg, bc_next, brow_reg, brow_next;
    logic [SUB_W-1:0] cib_reg, cib_next, rib_reg, rib_next;
    logic [SUB_W-1:0] crem_reg, crem_next, rrem_reg, rrem_next;
    logic [SEG_W-1:0] seg_reg, seg_next;

    // Position after frame start
    logic [POS_W-1:0] pc_e, pr_e, bc_e, brow_e;
    logic [SUB_W-1:0] cib_e, rib_e, crem_e, rrem_e;
    logic [SEG_W-1:0] seg_e, seg_add;
    logic             in_area, seg_end, blk_end, col_wrap, row_wrap, row_used;

    // Segment hand-off to the line store
    logic [SEG_W-1:0] acc_seg_reg;
    logic [POS_W-1:0] acc_addr_reg;
    logic [POS_W-1:0] acc_row_reg;
    logic             acc_first_reg;
    logic             acc_end_reg;
    logic             block_done_reg;
    logic [SUM_W-1:0] line_rd, acc_sum, blk_sum_reg;

    // Divider
    logic [DIV_W-1:0] div_dvd, div_dsr, div_q, div_r;
    logic             div_done;

    // Output register
    logic m_valid_reg, m_valid_next, out_load;

    // Config writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_cfg_reg <= SIDE_RESET;
            cols_cfg_reg <= COLS_RESET;
            rows_cfg_reg <= ROWS_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                CFG_BLOCK_SIDE: side_cfg_reg <= cfg_data[SIDE_REG_W-1:0];
                CFG_IMAGE_COLS: cols_cfg_reg <= cfg_data[DIM_REG_W-1:0];
                CFG_IMAGE_ROWS: rows_cfg_reg <= cfg_data[DIM_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp registers to their usable range
    always_comb begin
        if (side_cfg_reg == '0) begin
            side_c = SIDE_W'(1);
        end else if (32'(side_cfg_reg) > 32'(MAX_BLOCK_SIDE)) begin
            side_c = SIDE_W'(MAX_BLOCK_SIDE);
        end else begin
            side_c = SIDE_W'(side_cfg_reg);
        end
        if (cols_cfg_reg == '0) begin
            cols_c = CNT_W'(1);
        end else if (32'(cols_cfg_reg) > 32'(MAX_COLS)) begin
            cols_c = CNT_W'(MAX_COLS);
        end else begin
            cols_c = CNT_W'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            rows_c = CNT_W'(1);
        end else if (32'(rows_cfg_reg) > 32'(MAX_COLS)) begin
            rows_c = CNT_W'(MAX_COLS);
        end else begin
            rows_c = CNT_W'(rows_cfg_reg);
        end
    end

    assign side_m1 = side_c - SIDE_W'(1);
    assign side_sq = SQ_W'(side_c) * SQ_W'(side_c);

    // Frame start zeroes the position before this word is taken
    always_comb begin
        pc_e   = s_frame_start ? '0 : pc_reg;
        pr_e   = s_frame_start ? '0 : pr_reg;
        bc_e   = s_frame_start ? '0 : bc_reg;
        brow_e = s_frame_start ? '0 : brow_reg;
        cib_e  = s_frame_start ? '0 : cib_reg;
        rib_e  = s_frame_start ? '0 : rib_reg;
        crem_e = s_frame_start ? '0 : crem_reg;
        rrem_e = s_frame_start ? '0 : rrem_reg;
        seg_e  = s_frame_start ? '0 : seg_reg;
    end

    assign seg_add  = seg_e + SEG_W'(s_pixel);
    assign row_used = CNT_W'(brow_e) < rows_q_reg;
    assign in_area  = row_used && (CNT_W'(bc_e) < cols_q_reg);
    assign seg_end  = SIDE_W'(cib_e) >= side_m1;
    assign blk_end  = SIDE_W'(rib_e) >= side_m1;
    assign col_wrap = (CNT_W'(pc_e) + CNT_W'(1)) >= cols_c;
    assign row_wrap = (CNT_W'(pr_e) + CNT_W'(1)) >= rows_c;

    // Advance position and segment sum; load recomputed quotients
    always_comb begin
        pc_next     = pc_reg;
        pr_next     = pr_reg;
        bc_next     = bc_reg;
        brow_next   = brow_reg;
        cib_next    = cib_reg;
        rib_next    = rib_reg;
        crem_next   = crem_reg;
        rrem_next   = rrem_reg;
        seg_next    = seg_reg;
        cols_q_next = cols_q_reg;
        rows_q_next = rows_q_reg;
        if (cmd.accept) begin
            pc_next   = pc_e;
            pr_next   = pr_e;
            bc_next   = bc_e;
            brow_next = brow_e;
            cib_next  = cib_e;
            rib_next  = rib_e;
            crem_next = crem_e;
            rrem_next = rrem_e;
            seg_next  = seg_e;
            if (in_area) begin
                if (seg_end) begin
                    seg_next = '0;
                    cib_next = '0;
                end else begin
                    seg_next = seg_add;
                    cib_next = cib_e + SUB_W'(1);
                end
            end
            if (col_wrap) begin
                pc_next   = '0;
                cib_next  = '0;
                seg_next  = '0;
                bc_next   = '0;
                crem_next = '0;
                if (row_used) begin
                    rib_next = blk_end ? '0 : rib_e + SUB_W'(1);
                end
                if (row_wrap) begin
                    pr_next   = '0;
                    rib_next  = '0;
                    brow_next = '0;
                    rrem_next = '0;
                end else begin
                    pr_next = pr_e + POS_W'(1);
                    if (SIDE_W'(rrem_e) + SIDE_W'(1) == side_c) begin
                        rrem_next = '0;
                        brow_next = brow_e + POS_W'(1);
                    end else begin
                        rrem_next = rrem_e + SUB_W'(1);
                    end
                end
            end else begin
                pc_next = pc_e + POS_W'(1);
                if (SIDE_W'(crem_e) + SIDE_W'(1) == side_c) begin
                    crem_next = '0;
                    bc_next   = bc_e + POS_W'(1);
                end else begin
                    crem_next = crem_e + SUB_W'(1);
                end
            end
        end else if (cmd.div_load) begin
            unique case (cmd.op)
                OP_COLS: cols_q_next = CNT_W'(div_q);
                OP_ROWS: rows_q_next = CNT_W'(div_q);
                OP_PCOL: begin
                    bc_next   = POS_W'(div_q);
                    crem_next = SUB_W'(div_r);
                end
                OP_PROW: begin
                    brow_next = POS_W'(div_q);
                    rrem_next = SUB_W'(div_r);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= '0;
            pr_reg     <= '0;
            bc_reg     <= '0;
            brow_reg   <= '0;
            cib_reg    <= '0;
            rib_reg    <= '0;
            crem_reg   <= '0;
            rrem_reg   <= '0;
            seg_reg    <= '0;
            cols_q_reg <= '0;
            rows_q_reg <= '0;
        end else begin
            pc_reg     <= pc_next;
            pr_reg     <= pr_next;
            bc_reg     <= bc_next;
            brow_reg   <= brow_next;
            cib_reg    <= cib_next;
            rib_reg    <= rib_next;
            crem_reg   <= crem_next;
            rrem_reg   <= rrem_next;
            seg_reg    <= seg_next;
            cols_q_reg <= cols_q_next;
            rows_q_reg <= rows_q_next;
        end
    end

    // Hold the finished segment for the line store update
    always_ff @(posedge aclk) begin
        if (cmd.accept && in_area && seg_end) begin
            acc_seg_reg   <= seg_add;
            acc_addr_reg  <= bc_e;
            acc_row_reg   <= brow_e;
            acc_first_reg <= (rib_e == '0);
            acc_end_reg   <= (CNT_W'(bc_e) + CNT_W'(1) == cols_q_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_done_reg <= 1'b0;
        end else if (cmd.accept && in_area && seg_end) begin
            block_done_reg <= blk_end;
        end
    end

    // Line store of per-block-column sums
    bavg_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_COLS)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (cmd.acc_write),
        .wr_addr (acc_addr_reg),
        .wr_data (acc_sum),
        .rd_addr (bc_e),
        .rd_data (line_rd)
    );

    assign acc_sum = acc_first_reg ? SUM_W'(acc_seg_reg) : line_rd + SUM_W'(acc_seg_reg);

    always_ff @(posedge aclk) begin
        if (cmd.acc_write) begin
            blk_sum_reg <= acc_sum;
        end
    end

    // Select divider operands
    always_comb begin
        unique case (cmd.op)
            OP_COLS: begin
                div_dvd = DIV_W'(cols_c);
                div_dsr = DIV_W'(side_c);
            end
            OP_ROWS: begin
                div_dvd = DIV_W'(rows_c);
                div_dsr = DIV_W'(side_c);
            end
            OP_PCOL: begin
                div_dvd = DIV_W'(pc_reg);
                div_dsr = DIV_W'(side_c);
            end
            OP_PROW: begin
                div_dvd = DIV_W'(pr_reg);
                div_dsr = DIV_W'(side_c);
            end
            OP_BLOCK: begin
                div_dvd = DIV_W'(blk_sum_reg);
                div_dsr = DIV_W'(side_sq);
            end
            default: begin
                div_dvd = '0;
                div_dsr = DIV_W'(side_c);
            end
        endcase
    end

    bavg_div #(
        .WIDTH (DIV_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // Output register: load the block mean, drop valid when taken
    assign out_load     = cmd.div_load && (cmd.op == OP_BLOCK);
    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_avg_value <= PIXEL_BITS'(div_q);
            m_block_row <= acc_row_reg;
            m_block_col <= acc_addr_reg;
            m_row_end   <= acc_end_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // Status to the controller
    assign stat.seg_done   = in_area && seg_end;
    assign stat.block_done = block_done_reg;
    assign stat.div_done   = div_done;
    assign stat.cfg_write  = cfg_wr;
    assign stat.out_free   = !m_valid_reg || m_ready;

endmodule

/* src/bavg_ctrl.sv */
// Controller of the block average downsampler: sequences pixel intake,
// line store update, block division and geometry recompute.
// Depends on bavg_pkg.
module bavg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bavg_pkg::bavg_stat_t stat,
    output bavg_pkg::bavg_cmd_t  cmd
);

    import bavg_pkg::*;

    bavg_state_t state_reg, state_next;
    bavg_op_t    op_reg, op_next;
    logic        dirty_reg, dirty_next, dirty_clr;
    logic        accept;

    assign s_ready = (state_reg == ST_RUN) && !dirty_reg;
    assign accept  = s_valid && s_ready;

    // Recompute geometry after reset and after every config write
    assign dirty_next = stat.cfg_write || (dirty_reg && !dirty_clr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RUN;
            op_reg    <= OP_COLS;
            dirty_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            dirty_reg <= dirty_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        dirty_clr  = 1'b0;
        cmd        = '0;
        cmd.op     = op_reg;
        cmd.accept = accept;
        unique case (state_reg)
            ST_RUN: begin
                if (dirty_reg) begin
                    dirty_clr  = 1'b1;
                    op_next    = OP_COLS;
                    state_next = ST_DIV_START;
                end else if (accept && stat.seg_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                cmd.acc_write = 1'b1;
                if (stat.block_done) begin
                    op_next    = OP_BLOCK;
                    state_next = ST_DIV_START;
                end else begin
                    state_next = ST_RUN;
                end
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    if (op_reg == OP_BLOCK) begin
                        // hold the mean until the output register frees up
                        if (stat.out_free) begin
                            cmd.div_load = 1'b1;
                            state_next   = ST_RUN;
                        end
                    end else begin
                        cmd.div_load = 1'b1;
                        unique case (op_reg)
                            OP_COLS: begin
                                op_next    = OP_ROWS;
                                state_next = ST_DIV_START;
                            end
                            OP_ROWS: begin
                                op_next    = OP_PCOL;
                                state_next = ST_DIV_START;
                            end
                            OP_PCOL: begin
                                op_next    = OP_PROW;
                                state_next = ST_DIV_START;
                            end
                            default: state_next = ST_RUN;
                        endcase
                    end
                end
            end
            default: state_next = ST_RUN;
        endcase
    end

`ifndef SYNTHESIS
    a_seg_to_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && stat.seg_done |=> state_reg == ST_ACC)
        else $error("segment end not followed by line store update");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_load && cmd.op == OP_BLOCK |-> stat.out_free)
        else $error("block mean loaded over a waiting result");

    a_cfg_dirty: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.cfg_write |=> dirty_reg)
        else $error("config write did not schedule a recompute");
`endif

endmodule

/* dv/block_mean_checker.sv */
// Result checker for the block average downsampler testbench.
// Watches the pixel, result and register channels, predicts every block mean
// and compares it with the result words. Depends on bavg_pkg.
module block_mean_checker (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_valid,
    input  logic                                      s_ready,
    input  logic [bavg_pkg::DEF_PIXEL_BITS-1:0]       s_pixel,
    input  logic                                      s_frame_start,
    input  logic                                      m_valid,
    input  logic                                      m_ready,
    input  logic [bavg_pkg::DEF_PIXEL_BITS-1:0]       m_avg_value,
    input  logic [$clog2(bavg_pkg::DEF_MAX_COLS)-1:0] m_block_row,
    input  logic [$clog2(bavg_pkg::DEF_MAX_COLS)-1:0] m_block_col,
    input  logic                                      m_row_end,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [bavg_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [bavg_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                      run_done,
    output int                                        fail_count,
    output int                                        pending,
    output int                                        results_seen
);

    import bavg_pkg::*;

    localparam int PIX_W = DEF_PIXEL_BITS;
    localparam int POS_W = $clog2(DEF_MAX_COLS);

    typedef struct packed {
        logic [PIX_W-1:0] avg_value;
        logic [POS_W-1:0] block_row;
        logic [POS_W-1:0] block_col;
        logic             row_end;
    } block_mean_t;

    block_mean_t expected_blocks[$];

    // Shadow registers and position state of the block
    logic [SIDE_REG_W-1:0] side_reg;
    logic [DIM_REG_W-1:0]  cols_reg;
    logic [DIM_REG_W-1:0]  rows_reg;
    logic [15:0]           column_sums [DEF_MAX_COLS];
    logic [11:0]           segment_acc;
    logic [POS_W-1:0]      pix_col;
    logic [POS_W-1:0]      pix_row;
    logic [3:0]            col_pos;
    logic [3:0]            row_pos;
    logic                  leftover_checked;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the position by one pixel and queue a block mean when one completes
    task automatic predict_block_mean(input logic [PIX_W-1:0] px, input logic fs);
        int unsigned side;
        int unsigned cols;
        int unsigned rows;
        int unsigned across;
        int unsigned used_cols;
        int unsigned used_rows;
        int unsigned bc;
        logic [31:0] mean_q;
        logic [31:0] pos_q;
        block_mean_t blk;

        side      = clamp_dim(side_reg, DEF_MAX_BLOCK_SIDE);
        cols      = clamp_dim(cols_reg, DEF_MAX_COLS);
        rows      = clamp_dim(rows_reg, DEF_MAX_COLS);
        across    = cols / side;
        used_cols = across * side;
        used_rows = (rows / side) * side;

        // frame start clears the position before this pixel is taken
        if (fs) begin
            pix_col     = '0;
            pix_row     = '0;
            col_pos     = '0;
            row_pos     = '0;
            segment_acc = '0;
        end

        // accumulate only inside whole blocks; partial edges are dropped
        if (pix_row < used_rows && pix_col < used_cols) begin
            segment_acc = segment_acc + px;
            if (col_pos >= side - 1) begin
                bc = pix_col / side;
                if (row_pos == 0) column_sums[bc] = {4'd0, segment_acc};
                else column_sums[bc] = column_sums[bc] + segment_acc;
                if (row_pos >= side - 1) begin
                    mean_q        = column_sums[bc] / (side * side);
                    blk.avg_value = mean_q[PIX_W-1:0];
                    pos_q         = pix_row / side;
                    blk.block_row = pos_q[POS_W-1:0];
                    pos_q         = bc;
                    blk.block_col = pos_q[POS_W-1:0];
                    blk.row_end   = (bc == across - 1);
                    expected_blocks.push_back(blk);
                end
                segment_acc = '0;
                col_pos     = '0;
            end else begin
                col_pos = col_pos + 1'b1;
            end
        end

        // wrap at row end and at frame end
        if (pix_col + 1 >= cols) begin
            pix_col     = '0;
            col_pos     = '0;
            segment_acc = '0;
            if (pix_row < used_rows) begin
                if (row_pos >= side - 1) row_pos = '0;
                else row_pos = row_pos + 1'b1;
            end
            if (pix_row + 1 >= rows) begin
                pix_row = '0;
                row_pos = '0;
            end else begin
                pix_row = pix_row + 1'b1;
            end
        end else begin
            pix_col = pix_col + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        block_mean_t want;
        if (!aresetn) begin
            side_reg         = SIDE_RESET;
            cols_reg         = COLS_RESET;
            rows_reg         = ROWS_RESET;
            segment_acc      = '0;
            pix_col          = '0;
            pix_row          = '0;
            col_pos          = '0;
            row_pos          = '0;
            leftover_checked = 1'b0;
            fail_count       = 0;
            results_seen     = 0;
            expected_blocks.delete();
        end else begin
            // compare each result word with the oldest predicted block
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_blocks.size() == 0) begin
                    $error("result word with no block pending: avg_value %0d row %0d col %0d",
                           m_avg_value, m_block_row, m_block_col);
                    fail_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_avg_value !== want.avg_value) begin
                        $error("avg_value: expected %0d, actual %0d", want.avg_value, m_avg_value);
                        fail_count++;
                    end
                    if (m_block_row !== want.block_row) begin
                        $error("block_row: expected %0d, actual %0d", want.block_row, m_block_row);
                        fail_count++;
                    end
                    if (m_block_col !== want.block_col) begin
                        $error("block_col: expected %0d, actual %0d", want.block_col, m_block_col);
                        fail_count++;
                    end
                    if (m_row_end !== want.row_end) begin
                        $error("row_end: expected %0d, actual %0d", want.row_end, m_row_end);
                        fail_count++;
                    end
                end
            end

            // track register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_BLOCK_SIDE: side_reg = cfg_data[SIDE_REG_W-1:0];
                    CFG_IMAGE_COLS: cols_reg = cfg_data;
                    CFG_IMAGE_ROWS: rows_reg = cfg_data;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) predict_block_mean(s_pixel, s_frame_start);

            // flag blocks that never came out
            if (run_done && !leftover_checked) begin
                leftover_checked = 1'b1;
                if (expected_blocks.size() != 0) begin
                    $error("%0d predicted block means never arrived", expected_blocks.size());
                    fail_count += expected_blocks.size();
                end
            end
        end
        pending = expected_blocks.size();
    end

endmodule

/* dv/tb_block_average_downsampler.sv */
// Top of the block average downsampler testbench.
// Drives pixels, register writes and result back-pressure, and gives the
// verdict. Depends on bavg_pkg, block_mean_checker and the block itself.
module tb_block_average_downsampler;
    import bavg_pkg::*;

    localparam int PIX_W          = DEF_PIXEL_BITS;
    localparam int POS_W          = $clog2(DEF_MAX_COLS);
    localparam int DIRECTED_WORDS = 25;
    localparam int RANDOM_WORDS   = 1750;
    localparam int MODE_SPLIT     = (DIRECTED_WORDS + RANDOM_WORDS) / 3;
    localparam int DRAIN_CYCLES   = 48;
    localparam int HOLD_CYCLES    = 300;
    localparam int STALL_LIMIT    = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {
        PIX_RANDOM,
        PIX_MAX,
        PIX_ZERO,
        PIX_HIGH,
        PIX_RAMP
    } pixel_kind_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel       = '0;
    logic                  s_frame_start = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [PIX_W-1:0]      m_avg_value;
    logic [POS_W-1:0]      m_block_row;
    logic [POS_W-1:0]      m_block_col;
    logic                  m_row_end;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;
    logic                  run_done      = 1'b0;

    int fail_count;
    int pending;
    int results_seen;
    int words_sent  = 0;
    int cfg_count   = 0;
    int phase_count = 0;
    int s_idle_pct  = 26;
    int m_idle_pct  = 54;
    int hold_req    = 0;
    int cur_cols    = 640;
    int cur_rows    = 480;

    block_average_downsampler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_value   (m_avg_value),
        .m_block_row   (m_block_row),
        .m_block_col   (m_block_col),
        .m_row_end     (m_row_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    block_mean_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_avg_value   (m_avg_value),
        .m_block_row   (m_block_row),
        .m_block_col   (m_block_col),
        .m_row_end     (m_row_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .run_done      (run_done),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Drive result back-pressure; a hold request stalls the receiver for a long stretch
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= m_idle_pct);
            end
        end
    end

    // End the run when no channel moves a word for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) quiet = 0;
            else quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [PIX_W-1:0] next_pixel(input pixel_kind_t kind, input int idx);
        logic [31:0] rnd;
        case (kind)
            PIX_MAX:  rnd = 255;
            PIX_ZERO: rnd = 0;
            PIX_HIGH: rnd = $urandom_range(255, 240);
            PIX_RAMP: rnd = idx * 37;
            default:  rnd = $urandom_range(255);
        endcase
        return rnd[PIX_W-1:0];
    endfunction

    // Offer one pixel word and hold it until accepted; call and return at a falling edge
    task automatic send_word(input logic [PIX_W-1:0] px, input logic fs);
        if (words_sent < MODE_SPLIT) begin
            s_idle_pct = 26;
            m_idle_pct = 54;
        end else if (words_sent < 2 * MODE_SPLIT) begin
            s_idle_pct = 54;
            m_idle_pct = 26;
        end else begin
            s_idle_pct = 0;
            m_idle_pct = 0;
        end
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel       <= px;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic run_phase(input int n_words, input bit open_frame, input pixel_kind_t kind,
                             input int fs_noise_pct);
        for (int i = 0; i < n_words; i++) begin
            send_word(next_pixel(kind, i),
                      (i == 0 && open_frame) || ($urandom_range(99) < fs_noise_pct));
        end
        phase_count++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int data);
        logic [31:0] d;
        d = data;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d[CFG_DATA_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        cfg_count++;
    endtask

    // Write the geometry: all registers, or a random subset of them
    task automatic apply_geometry(input int side, input int cols, input int rows,
                                  input bit write_all);
        if (write_all || $urandom_range(3) != 0) begin
            cfg_write(CFG_BLOCK_SIDE, side);
        end
        if (write_all || $urandom_range(3) != 0) begin
            cfg_write(CFG_IMAGE_COLS, cols);
            cur_cols = cols;
        end
        if (write_all || $urandom_range(3) != 0) begin
            cfg_write(CFG_IMAGE_ROWS, rows);
            cur_rows = rows;
        end
        if ($urandom_range(19) == 0) cfg_write(CFG_UNUSED, $urandom_range(2047));
    endtask

    // Drop valid, wait for all block means, then let in-flight pixels settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int side;
        int cols;
        int rows;
        int eff_cols;
        int eff_rows;
        int n;
        int cap;
        int target;
        pixel_kind_t kind;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: two white blocks, side 0 acting as 1 on black, clipped edges with frame wrap
        apply_geometry(2, 4, 2, 1);
        run_phase(8, 1, PIX_MAX, 0);
        wait_drained();
        apply_geometry(0, 3, 1, 1);
        run_phase(3, 1, PIX_ZERO, 0);
        wait_drained();
        apply_geometry(2, 3, 3, 1);
        run_phase(14, 1, PIX_RAMP, 0);

        // Full-width line of single-pixel blocks; also fills every column sum entry
        wait_drained();
        apply_geometry(1, 2047, 1, 1);
        run_phase(1024, 1, PIX_RANDOM, 0);

        // Receiver holds off while pixels keep coming
        wait_drained();
        apply_geometry(1, 8, 4, 1);
        hold_req++;
        run_phase(32, 1, PIX_RANDOM, 0);

        // Largest block, oversized side register, brightest pixels
        wait_drained();
        apply_geometry(31, 16, 16, 1);
        run_phase(256, 1, PIX_MAX, 0);

        target = DIRECTED_WORDS + RANDOM_WORDS;
        while (words_sent < target) begin
            wait_drained();
            cap = 120;
            case ($urandom_range(9))
                0: begin
                    side = ($urandom_range(1) != 0) ? 16 : $urandom_range(31, 17);
                    cols = $urandom_range(20, 16);
                    rows = $urandom_range(17, 16);
                    cap  = 400;
                end
                1: begin
                    side = 0;
                    cols = $urandom_range(6, 1);
                    rows = $urandom_range(4, 1);
                end
                2: begin
                    side = $urandom_range(2, 1);
                    cols = $urandom_range(1);
                    rows = $urandom_range(3);
                end
                3: begin
                    side = $urandom_range(4, 1);
                    cols = $urandom_range(10, 2);
                    rows = ($urandom_range(1) != 0) ? 1024 : 2047;
                end
                default: begin
                    side = $urandom_range(5, 1);
                    cols = $urandom_range(24, 1);
                    rows = $urandom_range(12, 1);
                end
            endcase
            apply_geometry(side, cols, rows, 0);

            // size the phase from the effective frame of the current geometry
            eff_cols = (cur_cols < 1) ? 1 : ((cur_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cur_cols);
            eff_rows = (cur_rows < 1) ? 1 : ((cur_rows > DEF_MAX_COLS) ? DEF_MAX_COLS : cur_rows);
            n = eff_cols * eff_rows * $urandom_range(2, 1);
            if (n > cap) n = cap;
            if (n < 4) n = 4;
            if (n > target - words_sent) n = target - words_sent;

            case ($urandom_range(7))
                0:       kind = PIX_MAX;
                1:       kind = PIX_ZERO;
                2:       kind = PIX_HIGH;
                default: kind = PIX_RANDOM;
            endcase
            run_phase(n, $urandom_range(99) < 85, kind, 3);
        end

        wait_drained();
        run_done <= 1'b1;
        repeat (2) @(negedge aclk);

        $display("Sent %0d pixel words in %0d phases with %0d register writes;",
                 words_sent, phase_count, cfg_count);
        $display("checked %0d block means over sides 0 to 31, clipped edges and mid-frame changes.",
                 results_seen);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
